// File: rtl/core/sbfp_pkg.sv
// ----------------------------------------------------------------------------
// sbfp_pkg: shared types and constants of the shift buffer
// Slot counts, field widths, result kinds, register indexes and the small
// structs that pass between the decision logic and the slot array.
// ----------------------------------------------------------------------------
package sbfp_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned REG_IDX_W = 2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CAP_W-1:0]     cap_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [SLOTS-1:0]     slot_mask_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_FORWARD   = 3'd1,
    KIND_BULK      = 3'd2,
    KIND_DISCARD   = 3'd3,
    KIND_REPLACED  = 3'd4,
    KIND_CAP_ERROR = 3'd5
  } kind_t;

  // Configuration register indexes
  localparam reg_idx_t REG_ADV_MODE = 2'd0;
  localparam reg_idx_t REG_POLICY   = 2'd1;
  localparam reg_idx_t REG_CAPACITY = 2'd2;

  // Full policy codes; the unused code behaves as discard
  localparam logic [1:0] POL_DISCARD = 2'd0;
  localparam logic [1:0] POL_BULK    = 2'd1;
  localparam logic [1:0] POL_REPLACE = 2'd2;

  // Input item mode and advance mode codes
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;
  localparam logic ADV_ARRIVAL  = 1'b0;
  localparam logic ADV_SIGNAL   = 1'b1;

  localparam cap_t CAP_RESET = cap_t'(SLOTS);

  // Slot array update requested by the decision logic
  typedef struct packed {
    logic shift;     // move every used slot one place toward the front
    logic shift_in;  // the last used slot takes the arrival after a shift
    logic fill;      // write the arrival into the first free slot
    logic replace;   // overwrite the last used slot with the arrival
  } act_t;

  // Slot contents the decision logic looks at
  typedef struct packed {
    logic front_valid;
    id_t  front_entity;
    logic last_valid;
    id_t  last_entity;
  } view_t;

  // Saturate a programmed capacity to the number of physical slots
  function automatic cap_t eff_cap(input cap_t cap);
    eff_cap = (cap > cap_t'(SLOTS)) ? cap_t'(SLOTS) : cap;
  endfunction

endpackage

// File: rtl/core/sbfp_ctrl.sv
// ----------------------------------------------------------------------------
// sbfp_ctrl: per-transaction decision logic
// Picks the result kind and entity for one item and the slot update that
// goes with it, from the mode registers and the current front and last slot.
// ----------------------------------------------------------------------------
module sbfp_ctrl (
  input  logic             mode,
  input  sbfp_pkg::id_t    entity_id,
  input  logic             adv_mode,
  input  logic [1:0]       policy,
  input  sbfp_pkg::cap_t   num_slots,
  input  sbfp_pkg::view_t  view,
  output sbfp_pkg::kind_t  kind,
  output sbfp_pkg::id_t    entity,
  output sbfp_pkg::act_t   act
);

  logic empty_cap;

  assign empty_cap = (num_slots == '0);

  always_comb begin
    kind   = sbfp_pkg::KIND_NONE;
    entity = '0;
    act    = '0;
    if (mode == sbfp_pkg::MODE_TICK) begin
      if (adv_mode == sbfp_pkg::ADV_SIGNAL && !empty_cap) begin
        act.shift = 1'b1;
        if (view.front_valid) begin
          kind   = sbfp_pkg::KIND_FORWARD;
          entity = view.front_entity;
        end
      end
    end else if (empty_cap) begin
      kind   = sbfp_pkg::KIND_CAP_ERROR;
      entity = entity_id;
    end else if (adv_mode == sbfp_pkg::ADV_ARRIVAL) begin
      act.shift    = 1'b1;
      act.shift_in = 1'b1;
      if (view.front_valid) begin
        kind   = sbfp_pkg::KIND_FORWARD;
        entity = view.front_entity;
      end
    end else if (view.last_valid) begin
      // last slot taken: apply the full policy
      case (policy)
        sbfp_pkg::POL_BULK: begin
          kind   = sbfp_pkg::KIND_BULK;
          entity = entity_id;
        end
        sbfp_pkg::POL_REPLACE: begin
          kind        = sbfp_pkg::KIND_REPLACED;
          entity      = view.last_entity;
          act.replace = 1'b1;
        end
        default: begin
          kind   = sbfp_pkg::KIND_DISCARD;
          entity = entity_id;
        end
      endcase
    end else begin
      act.fill = 1'b1;
    end
  end

endmodule

// File: rtl/core/sbfp_slots.sv
// ----------------------------------------------------------------------------
// sbfp_slots: slot array of the shift buffer
// Holds the entity and valid bit of each slot and applies shift, fill,
// replace and capacity clear.
// ----------------------------------------------------------------------------
module sbfp_slots (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  sbfp_pkg::act_t  act,
  input  sbfp_pkg::id_t   entity_id,
  input  sbfp_pkg::cap_t  num_slots,
  input  logic            cap_we,
  input  sbfp_pkg::cap_t  cap_wdata,
  output sbfp_pkg::view_t view
);

  sbfp_pkg::slot_mask_t valid;
  sbfp_pkg::slot_mask_t valid_next;
  sbfp_pkg::id_t        ent      [sbfp_pkg::SLOTS];
  sbfp_pkg::id_t        ent_next [sbfp_pkg::SLOTS];

  sbfp_pkg::cap_t       last_m1;
  sbfp_pkg::idx_t       last_idx;
  sbfp_pkg::cap_t       new_slots;
  sbfp_pkg::slot_mask_t free_mask;
  sbfp_pkg::slot_mask_t first_free;

  assign last_m1   = num_slots - sbfp_pkg::cap_t'(1);
  assign last_idx  = last_m1[sbfp_pkg::IDX_W-1:0];
  assign new_slots = sbfp_pkg::eff_cap(cap_wdata);

  assign view.front_valid  = valid[0];
  assign view.front_entity = ent[0];
  assign view.last_valid   = valid[last_idx];
  assign view.last_entity  = ent[last_idx];

  always_comb begin
    for (int i = 0; i < sbfp_pkg::SLOTS; i++) begin
      free_mask[i] = !valid[i] && (sbfp_pkg::cap_t'(i) < num_slots);
    end
  end

  // isolate the lowest free slot
  assign first_free = free_mask & (~free_mask + sbfp_pkg::slot_mask_t'(1));

  always_comb begin
    for (int i = 0; i < sbfp_pkg::SLOTS; i++) begin
      valid_next[i] = valid[i];
      ent_next[i]   = ent[i];
      if (en && act.shift) begin
        if (sbfp_pkg::cap_t'(i) + sbfp_pkg::cap_t'(1) == num_slots) begin
          valid_next[i] = act.shift_in;
          ent_next[i]   = entity_id;
        end else if (sbfp_pkg::cap_t'(i) + sbfp_pkg::cap_t'(1) < num_slots) begin
          // the top slot never takes this arm, so the wrapped index is unused
          valid_next[i] = valid[sbfp_pkg::idx_t'(i + 1)];
          ent_next[i]   = ent[sbfp_pkg::idx_t'(i + 1)];
        end
      end
      if (en && act.fill && first_free[i]) begin
        valid_next[i] = 1'b1;
        ent_next[i]   = entity_id;
      end
      if (en && act.replace && sbfp_pkg::idx_t'(i) == last_idx) begin
        ent_next[i] = entity_id;
      end
      // drop slots beyond a newly written capacity
      if (cap_we && sbfp_pkg::cap_t'(i) >= new_slots) begin
        valid_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sbfp_pkg::SLOTS; i++) begin
      ent[i] <= ent_next[i];
    end
  end

endmodule

// File: rtl/core/shift_buffer_with_full_policy_unit.sv
// ----------------------------------------------------------------------------
// shift_buffer_with_full_policy_unit: shift buffer with full-buffer policy
// Accepts arrivals and advance ticks, keeps up to sixteen slots and returns
// exactly one result per transaction.
// ----------------------------------------------------------------------------
// Path: an input waits in the input register until the result register is
// free or read; its result is then registered as the slot array updates.
// Throughput: one transaction per cycle while results are taken; slot update
// and result register load at the same edge, which frees the input register.
// Reset: slots empty, arrival-advance mode, discard policy, capacity 16.
module shift_buffer_with_full_policy_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  sbfp_pkg::id_t        entity_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           result_kind,
  output sbfp_pkg::id_t        result_entity,
  input  logic                 cfg_we,
  input  sbfp_pkg::reg_idx_t   cfg_addr,
  input  sbfp_pkg::cap_t       cfg_wdata
);

  // configuration
  logic           adv_mode;
  logic [1:0]     policy;
  sbfp_pkg::cap_t capacity;
  sbfp_pkg::cap_t num_slots;

  // input register
  logic           s1_valid;
  logic           s1_mode;
  sbfp_pkg::id_t  s1_id;
  logic           advance;

  // result register
  sbfp_pkg::kind_t out_kind;
  sbfp_pkg::id_t   out_ent;

  sbfp_pkg::kind_t kind;
  sbfp_pkg::id_t   entity;
  sbfp_pkg::act_t  act;
  sbfp_pkg::view_t view;
  logic            cap_we;

  assign num_slots = sbfp_pkg::eff_cap(capacity);
  assign cap_we    = cfg_we && (cfg_addr == sbfp_pkg::REG_CAPACITY);

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_mode <= sbfp_pkg::ADV_ARRIVAL;
      policy   <= sbfp_pkg::POL_DISCARD;
      capacity <= sbfp_pkg::CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbfp_pkg::REG_ADV_MODE: adv_mode <= cfg_wdata[0];
        sbfp_pkg::REG_POLICY:   policy   <= cfg_wdata[1:0];
        sbfp_pkg::REG_CAPACITY: capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_id   <= entity_id;
    end
  end

  sbfp_ctrl u_ctrl (
    .mode      (s1_mode),
    .entity_id (s1_id),
    .adv_mode  (adv_mode),
    .policy    (policy),
    .num_slots (num_slots),
    .view      (view),
    .kind      (kind),
    .entity    (entity),
    .act       (act)
  );

  sbfp_slots u_slots (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .act       (act),
    .entity_id (s1_id),
    .num_slots (num_slots),
    .cap_we    (cap_we),
    .cap_wdata (cfg_wdata),
    .view      (view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= kind;
      out_ent  <= entity;
    end
  end

  assign result_kind   = out_kind;
  assign result_entity = out_ent;

`ifndef SYNTHESIS
  // a pending transaction holds in the input register until it moves on
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_id) && $stable(s1_mode))
    else $error("input register lost a pending transaction");

  // a result with no kind carries no entity
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == sbfp_pkg::KIND_NONE |-> result_entity == '0)
    else $error("empty result carries an entity");

  // an arrival with zero capacity reports a capacity error
  a_cap_error: assert property (@(posedge clk) disable iff (rst)
    advance && s1_mode == sbfp_pkg::MODE_ARRIVAL && num_slots == '0
      |=> out_valid && result_kind == sbfp_pkg::KIND_CAP_ERROR)
    else $error("zero-capacity arrival without capacity error");

  // an empty result register never stalls the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");
`endif

endmodule

// File: tb/shift_buffer_with_full_policy_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_buffer_with_full_policy_unit_tb: self-checking bench for the buffer
// Walks a directed table of arrivals, ticks and register writes, then runs
// random phases that sweep advance mode, full policy and capacity. Every
// accepted transaction goes through a local slot model; results are matched
// in order against the queue of predicted results, with random gaps and
// stalls on both channels.
// ----------------------------------------------------------------------------
module shift_buffer_with_full_policy_unit_tb;

  localparam int CLK_HALF    = 10;
  localparam int IDLE_LIMIT  = 1000;
  localparam int N_PHASES    = 16;
  localparam int PHASE_ITEMS = 44;
  localparam int DRAIN       = 10;
  localparam int N_ROWS      = 31;

  // the one policy code the package leaves unnamed; it acts as discard
  localparam logic [1:0] POL_UNUSED = 2'd3;

  localparam bit ROW_ITEM = 1'b0;
  localparam bit ROW_CFG  = 1'b1;
  localparam bit PRED     = 1'b0;
  localparam bit TYPED    = 1'b1;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  sbfp_pkg::id_t      entity_id;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         result_kind;
  sbfp_pkg::id_t      result_entity;
  logic               cfg_we;
  sbfp_pkg::reg_idx_t cfg_addr;
  sbfp_pkg::cap_t     cfg_wdata;

  typedef struct packed {
    sbfp_pkg::kind_t kind;
    sbfp_pkg::id_t   ent;
  } result_t;

  typedef struct packed {
    bit                 is_cfg;
    sbfp_pkg::reg_idx_t addr;
    sbfp_pkg::cap_t     wdata;
    logic               md;
    sbfp_pkg::id_t      id;
    bit                 typed;
    sbfp_pkg::kind_t    kind;
    sbfp_pkg::id_t      ent;
  } row_t;

  result_t pending_results[$];

  // slot model and register copies
  sbfp_pkg::id_t  buf_id   [sbfp_pkg::SLOTS];
  logic           buf_full [sbfp_pkg::SLOTS];
  logic           cur_adv;
  logic [1:0]     cur_policy;
  sbfp_pkg::cap_t cur_cap;

  int errors;
  int idle_cycles;
  bit burst;

  row_t plan [0:N_ROWS-1] = '{
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'hFFFF, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'hA5A5, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h0000, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_CFG, sbfp_pkg::REG_CAPACITY, 5'd1, sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h1234, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h0001, TYPED,
      sbfp_pkg::KIND_FORWARD, 16'h1234},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h8000, TYPED,
      sbfp_pkg::KIND_FORWARD, 16'h0001},
    '{ROW_CFG, sbfp_pkg::REG_CAPACITY, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'hABCD, TYPED,
      sbfp_pkg::KIND_CAP_ERROR, 16'hABCD},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'h5A5A, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_CFG, sbfp_pkg::REG_ADV_MODE, sbfp_pkg::cap_t'(sbfp_pkg::ADV_SIGNAL),
      sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED, sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'hFFFF, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'hFFFF, TYPED,
      sbfp_pkg::KIND_CAP_ERROR, 16'hFFFF},
    '{ROW_CFG, sbfp_pkg::REG_CAPACITY, 5'd2, sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h1111, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h2222, TYPED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h3333, TYPED,
      sbfp_pkg::KIND_DISCARD, 16'h3333},
    '{ROW_CFG, sbfp_pkg::REG_POLICY, sbfp_pkg::cap_t'(sbfp_pkg::POL_BULK),
      sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED, sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h4444, TYPED,
      sbfp_pkg::KIND_BULK, 16'h4444},
    '{ROW_CFG, sbfp_pkg::REG_POLICY, sbfp_pkg::cap_t'(sbfp_pkg::POL_REPLACE),
      sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED, sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h5555, TYPED,
      sbfp_pkg::KIND_REPLACED, 16'h2222},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h6666, TYPED,
      sbfp_pkg::KIND_REPLACED, 16'h5555},
    '{ROW_CFG, sbfp_pkg::REG_POLICY, sbfp_pkg::cap_t'(POL_UNUSED),
      sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED, sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h7777, TYPED,
      sbfp_pkg::KIND_DISCARD, 16'h7777},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'h0000, TYPED,
      sbfp_pkg::KIND_FORWARD, 16'h1111},
    // grow past the physical slot count; the new slots start empty
    '{ROW_CFG, sbfp_pkg::REG_CAPACITY, 5'd31, sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'hFFFF, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'h0000, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'h0000, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_ARRIVAL, 16'hFFFF, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000},
    '{ROW_ITEM, sbfp_pkg::REG_ADV_MODE, 5'd0, sbfp_pkg::MODE_TICK, 16'h1234, PRED,
      sbfp_pkg::KIND_NONE, 16'h0000}
  };

  shift_buffer_with_full_policy_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .entity_id     (entity_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .result_entity (result_entity),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned used_slots();
    return (cur_cap > sbfp_pkg::SLOTS) ? sbfp_pkg::SLOTS : int'(cur_cap);
  endfunction

  // advance slots 0..n-1 one place toward the front, load the tail
  function automatic void shift_slots(int unsigned n, logic load, sbfp_pkg::id_t id);
    for (int i = 0; i + 1 < n; i++) begin
      buf_id[i]   = buf_id[i+1];
      buf_full[i] = buf_full[i+1];
    end
    buf_full[n-1] = load;
    buf_id[n-1]   = load ? id : '0;
  endfunction

  function automatic void apply_reg_write(sbfp_pkg::reg_idx_t addr, sbfp_pkg::cap_t data);
    int unsigned n;
    case (addr)
      sbfp_pkg::REG_ADV_MODE: cur_adv = data[0];
      sbfp_pkg::REG_POLICY:   cur_policy = data[1:0];
      sbfp_pkg::REG_CAPACITY: begin
        cur_cap = data;
        n = used_slots();
        // drop everything beyond the new capacity
        for (int i = n; i < sbfp_pkg::SLOTS; i++) begin
          buf_full[i] = 1'b0;
          buf_id[i]   = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t predict_event(logic md, sbfp_pkg::id_t id);
    result_t     r;
    int unsigned n;
    bit          placed;
    r.kind = sbfp_pkg::KIND_NONE;
    r.ent  = '0;
    n = used_slots();
    if (md == sbfp_pkg::MODE_TICK) begin
      if (cur_adv == sbfp_pkg::ADV_SIGNAL && n > 0) begin
        if (buf_full[0]) begin
          r.kind = sbfp_pkg::KIND_FORWARD;
          r.ent  = buf_id[0];
        end
        shift_slots(n, 1'b0, '0);
      end
    end else if (n == 0) begin
      r.kind = sbfp_pkg::KIND_CAP_ERROR;
      r.ent  = id;
    end else if (cur_adv == sbfp_pkg::ADV_ARRIVAL) begin
      if (buf_full[0]) begin
        r.kind = sbfp_pkg::KIND_FORWARD;
        r.ent  = buf_id[0];
      end
      shift_slots(n, 1'b1, id);
    end else if (buf_full[n-1]) begin
      case (cur_policy)
        sbfp_pkg::POL_BULK: begin
          r.kind = sbfp_pkg::KIND_BULK;
          r.ent  = id;
        end
        sbfp_pkg::POL_REPLACE: begin
          r.kind      = sbfp_pkg::KIND_REPLACED;
          r.ent       = buf_id[n-1];
          buf_id[n-1] = id;
        end
        default: begin
          r.kind = sbfp_pkg::KIND_DISCARD;
          r.ent  = id;
        end
      endcase
    end else begin
      placed = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!placed && !buf_full[i]) begin
          buf_full[i] = 1'b1;
          buf_id[i]   = id;
          placed      = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(logic md, sbfp_pkg::id_t id, result_t fixed, bit typed);
    int unsigned gap;
    result_t     r;
    result_t     expected;
    gap = burst ? 0 : $urandom_range(0, 13);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= md;
    entity_id <= id;
    do @(posedge clk); while (!in_ready);
    r = predict_event(md, id);
    expected = typed ? fixed : r;
    pending_results = {pending_results, expected};
  endtask

  // write only once every outstanding transaction has come back
  task automatic write_reg(sbfp_pkg::reg_idx_t addr, sbfp_pkg::cap_t data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg_write(addr, data);
  endtask

  // result side: random stall per transaction, in-order compare
  initial begin
    int unsigned stall;
    result_t     want;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_kind, sbfp_pkg::KIND_NONE);
      end else begin
        want = pending_results.pop_front();
        if (result_kind != want.kind)
          report_mismatch("result_kind", result_kind, want.kind);
        if (result_entity != want.ent)
          report_mismatch("result_entity", result_entity, want.ent);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    result_t fixed;
    result_t none;
    errors     = 0;
    burst      = 1'b0;
    none       = '{sbfp_pkg::KIND_NONE, '0};
    cur_adv    = sbfp_pkg::ADV_ARRIVAL;
    cur_policy = sbfp_pkg::POL_DISCARD;
    cur_cap    = sbfp_pkg::CAP_RESET;
    for (int i = 0; i < sbfp_pkg::SLOTS; i++) begin
      buf_id[i]   = '0;
      buf_full[i] = 1'b0;
    end

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= sbfp_pkg::MODE_ARRIVAL;
    entity_id <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= sbfp_pkg::REG_ADV_MODE;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].addr, plan[i].wdata);
      end else begin
        fixed.kind = plan[i].kind;
        fixed.ent  = plan[i].ent;
        send_item(plan[i].md, plan[i].id, fixed, plan[i].typed);
      end
    end

    // sweep mode and policy; capacity mostly small so the buffer fills often
    for (int p = 0; p < N_PHASES; p++) begin
      int unsigned    start;
      int unsigned    pick;
      int unsigned    tick_pct;
      sbfp_pkg::cap_t adv_word;
      sbfp_pkg::cap_t pol_word;
      sbfp_pkg::cap_t cap_word;
      logic           md;
      sbfp_pkg::id_t  id;
      burst = ($urandom_range(0, 3) == 0);
      adv_word      = sbfp_pkg::cap_t'($urandom_range(0, 31));
      adv_word[0]   = p[0];
      pol_word      = sbfp_pkg::cap_t'($urandom_range(0, 31));
      pol_word[1:0] = p[2:1];
      pick = $urandom_range(0, 9);
      if (pick == 0)      cap_word = '0;
      else if (pick <= 4) cap_word = sbfp_pkg::cap_t'($urandom_range(1, 4));
      else if (pick == 5) cap_word = sbfp_pkg::cap_t'(sbfp_pkg::SLOTS);
      else if (pick == 6) cap_word = sbfp_pkg::cap_t'($urandom_range(sbfp_pkg::SLOTS + 1, 31));
      else                cap_word = sbfp_pkg::cap_t'($urandom_range(1, sbfp_pkg::SLOTS));
      start = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case ((start + k) % 3)
          0:       write_reg(sbfp_pkg::REG_ADV_MODE, adv_word);
          1:       write_reg(sbfp_pkg::REG_POLICY, pol_word);
          default: write_reg(sbfp_pkg::REG_CAPACITY, cap_word);
        endcase
      end
      tick_pct = $urandom_range(15, 60);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        md   = ($urandom_range(0, 99) < tick_pct) ? sbfp_pkg::MODE_TICK
                                                   : sbfp_pkg::MODE_ARRIVAL;
        pick = $urandom_range(0, 7);
        if (pick == 0)      id = '0;
        else if (pick == 1) id = '1;
        else                id = sbfp_pkg::id_t'($urandom);
        send_item(md, id, none, PRED);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // hold a little longer to catch stray results
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
